### hw/rtl/smvlq_pkg.sv
package smvlq_pkg;

  localparam int POS_WIDTH  = 20;
  localparam int FOLD_WIDTH = POS_WIDTH + 1;
  localparam int DIGIT_BITS = 5;
  localparam int NUM_FIELDS = 4;
  localparam int IDX_WIDTH  = $clog2(NUM_FIELDS);
  localparam int CHAR_WIDTH = 7;

  localparam logic [CHAR_WIDTH-1:0] COMMA_CHAR = 7'h2C;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_COMMA
  } st_t;

  // base64 alphabet lookup
  function automatic logic [CHAR_WIDTH-1:0] b64_char(input logic [DIGIT_BITS:0] d);
    logic [CHAR_WIDTH-1:0] c;
    c = 7'h2F;
    case (d) inside
      [6'd0:6'd25]:  c = 7'h41 + {1'b0, d};
      [6'd26:6'd51]: c = 7'h61 + {1'b0, d} - 7'd26;
      [6'd52:6'd61]: c = 7'h30 + {1'b0, d} - 7'd52;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

### hw/rtl/source_map_vlq_mapping_encoder_unit.sv
// an item is taken in the idle state; its first character leaves the emit state after the
// load state has formed the first delta; per field the load state forms the delta and the
// emit state sends its digits, and the comma state then closes the item
// the digit shift register emits one 5-bit digit a cycle unless out_stall holds it
// one item is in flight at a time
// synchronous active-low reset clears the stored previous positions to zero and idles
module source_map_vlq_mapping_encoder_unit
  import smvlq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [POS_WIDTH-1:0]  in_gen_column,
  input  logic [POS_WIDTH-1:0]  in_src_index,
  input  logic [POS_WIDTH-1:0]  in_src_line,
  input  logic [POS_WIDTH-1:0]  in_src_column,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CHAR_WIDTH-1:0] out_char,
  output logic                  out_last
);

  st_t                    state_r, state_nxt;
  logic [IDX_WIDTH-1:0]   idx_r, idx_nxt;
  logic [FOLD_WIDTH-1:0]  sh_r, sh_nxt;
  logic [POS_WIDTH-1:0]   field_r [NUM_FIELDS];
  logic [POS_WIDTH-1:0]   prev_r  [NUM_FIELDS];

  logic                   in_acc, out_acc;
  logic [POS_WIDTH-1:0]   cur, prv, d_fwd, d_bwd;
  logic                   neg;
  logic [FOLD_WIDTH-1:0]  rest;
  logic                   cont;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // delta of the field in turn, sign folded into bit 0
  assign cur   = field_r[idx_r];
  assign prv   = prev_r[idx_r];
  assign neg   = cur < prv;
  assign d_fwd = cur - prv;
  assign d_bwd = prv - cur;

  assign rest = sh_r >> DIGIT_BITS;
  assign cont = rest != '0;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    sh_nxt    = sh_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    out_last  = 1'b0;
    out_char  = b64_char({cont, sh_r[DIGIT_BITS-1:0]});
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          idx_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        sh_nxt    = neg ? {d_bwd, 1'b1} : {d_fwd, 1'b0};
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_acc) begin
          if (cont) begin
            sh_nxt = rest;
          end else if (idx_r == IDX_WIDTH'(NUM_FIELDS - 1)) begin
            state_nxt = ST_COMMA;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_COMMA: begin
        out_valid = 1'b1;
        out_last  = 1'b1;
        out_char  = COMMA_CHAR;
        if (out_acc) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sh_r  <= sh_nxt;
    if (in_acc) begin
      field_r[0] <= in_gen_column;
      field_r[1] <= in_src_index;
      field_r[2] <= in_src_line;
      field_r[3] <= in_src_column;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FIELDS; i++) begin
        prev_r[i] <= '0;
      end
    end else if (state_r == ST_LOAD) begin
      prev_r[idx_r] <= cur;
    end
  end

endmodule

### hw/rtl/smvlq_chk.sv
module smvlq_chk
  import smvlq_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CHAR_WIDTH-1:0] out_char,
  input logic                  out_last
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output item changed");

  // one item in flight
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_comma_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char == COMMA_CHAR) == out_last))
    else $error("comma and last disagree");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
    else $error("no return to idle after comma");

  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("output while accepting input");

endmodule

bind source_map_vlq_mapping_encoder_unit smvlq_chk u_smvlq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_last  (out_last)
);
